### rtl/core/ktes_pkg.sv
// ----------------------------------------------------------------------------
// ktes_pkg
// Shared types, constants and the key compare for the key/tag exchange sorter.
// ----------------------------------------------------------------------------
package ktes_pkg;

	localparam int KEY_W    = 32;
	localparam int TAG_W    = 12;
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic        [TAG_W-1:0] tag;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_HOLD,
		ST_SCAN,
		ST_PUT,
		ST_E_RD,
		ST_E_CHK,
		ST_E_END
	} state_t;

	// signed greater-than, the one compare unit of the sort
	function automatic logic key_gt(input logic signed [KEY_W-1:0] a,
	                                input logic signed [KEY_W-1:0] b);
		return a > b;
	endfunction

endpackage

### rtl/core/ktes_ram.sv
// ----------------------------------------------------------------------------
// ktes_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/key_tag_exchange_sort.sv
// ----------------------------------------------------------------------------
// key_tag_exchange_sort
// Collects key/tag records, exchange-sorts them by signed key on the last
// record and streams the sorted set out, optionally skipping zero keys.
//
//   channel  signals                                         direction
//   in       in_valid/in_stall, sort_key, record_tag,        into block
//            last_record
//   out      out_valid/out_stall, sorted_key, sorted_tag,    out of block
//            final_result, records_dropped
//   cfg      cfg_write, cfg_data (skip_zero_keys)            into block
//
// load: one record per cycle unless in_stall; the store is one RAM port pair
// sort: START, then HOLD, SCAN run, PUT per pass; one compare per SCAN cycle
// emit: E_RD, E_CHK takes one record per cycle unless out_stall, E_END closes
// in_stall stays high from the last record until any closing record is staged
// async reset clears control state; store contents are not cleared
// ----------------------------------------------------------------------------
module key_tag_exchange_sort (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic                              cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ktes_pkg::KEY_W-1:0] sort_key,
	input  logic        [ktes_pkg::TAG_W-1:0] record_tag,
	input  logic                              last_record,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ktes_pkg::KEY_W-1:0] sorted_key,
	output logic        [ktes_pkg::TAG_W-1:0] sorted_tag,
	output logic                              final_result,
	output logic                              records_dropped
);

	import ktes_pkg::*;

	state_t state_q, state_d;

	logic              skip_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] i_q;
	logic [ADDR_W-1:0] j_q;
	rec_t              held_q;
	rec_t              pend_q;
	logic              pend_v_q;
	logic              out_valid_q;
	rec_t              out_rec_q;
	logic              out_final_q;
	logic              out_drop_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	rec_t              ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [REC_W-1:0]  ram_rdata;
	rec_t              rd_rec;

	logic             acc;
	logic             has_room;
	logic [CNT_W-1:0] last_idx;
	logic             j_at_last;
	logic             i_next_last;
	logic             swap;
	logic             keep;
	logic             out_free;
	logic             emit_adv;
	logic             out_load;
	logic             out_load_final;

	assign rd_rec      = rec_t'(ram_rdata);
	assign acc         = in_valid && !in_stall;
	assign has_room    = count_q < CNT_W'(CAPACITY);
	assign last_idx    = count_q - CNT_W'(1);
	assign j_at_last   = CNT_W'(j_q) == last_idx;
	assign i_next_last = (CNT_W'(i_q) + CNT_W'(1)) == last_idx;
	assign swap        = key_gt(held_q.key, rd_rec.key);
	assign keep        = !(skip_q && (rd_rec.key == '0));
	assign out_free    = !out_valid_q || !out_stall;
	assign emit_adv    = !(keep && pend_v_q && !out_free);

	ktes_ram #(
		.WIDTH(REC_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && last_record) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (count_q < CNT_W'(2)) ? ST_E_RD : ST_HOLD;
			end
			ST_HOLD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (j_at_last) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				state_d = i_next_last ? ST_E_RD : ST_HOLD;
			end
			ST_E_RD: begin
				state_d = ST_E_CHK;
			end
			ST_E_CHK: begin
				if (emit_adv && j_at_last) begin
					state_d = ST_E_END;
				end
			end
			ST_E_END: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall       = 1'b1;
		ram_we         = 1'b0;
		ram_waddr      = j_q;
		ram_wdata      = held_q;
		ram_raddr      = j_q;
		out_load       = 1'b0;
		out_load_final = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				ram_we    = acc && has_room;
				ram_waddr = count_q[ADDR_W-1:0];
				ram_wdata = '{key: sort_key, tag: record_tag};
			end
			ST_START: begin
				ram_raddr = '0;
			end
			ST_HOLD: begin
				ram_raddr = i_q + ADDR_W'(1);
			end
			ST_SCAN: begin
				ram_we    = swap;
				ram_raddr = j_q + ADDR_W'(1);
			end
			ST_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_raddr = i_q + ADDR_W'(1);
			end
			ST_E_RD: begin
				ram_raddr = j_q;
			end
			ST_E_CHK: begin
				ram_raddr = emit_adv ? (j_q + ADDR_W'(1)) : j_q;
				out_load  = emit_adv && keep && pend_v_q;
			end
			ST_E_END: begin
				out_load_final = pend_v_q && out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			skip_q      <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				skip_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_START: begin
					i_q <= '0;
					j_q <= '0;
				end
				ST_HOLD: begin
					j_q <= i_q + ADDR_W'(1);
				end
				ST_SCAN: begin
					j_q <= j_q + ADDR_W'(1);
				end
				ST_PUT: begin
					i_q <= i_q + ADDR_W'(1);
					j_q <= '0;
				end
				ST_E_CHK: begin
					if (emit_adv) begin
						j_q <= j_q + ADDR_W'(1);
						if (keep) begin
							pend_v_q <= 1'b1;
						end
					end
				end
				ST_E_END: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						count_q  <= '0;
						ovf_q    <= 1'b0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
			if (out_load || out_load_final) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD) begin
			held_q <= rd_rec;
		end else if (state_q == ST_SCAN && swap) begin
			held_q <= rd_rec;
		end
		if (state_q == ST_E_CHK && emit_adv && keep) begin
			pend_q <= rd_rec;
		end
		if (out_load || out_load_final) begin
			out_rec_q   <= pend_q;
			out_final_q <= out_load_final;
			out_drop_q  <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sorted_key      = out_rec_q.key;
	assign sorted_tag      = out_rec_q.tag;
	assign final_result    = out_final_q;
	assign records_dropped = out_drop_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count beyond capacity");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (j_q > i_q))
		else $error("scan index not past hold index");

	a_sort_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD || state_q == ST_SCAN || state_q == ST_PUT)
		|-> (count_q >= CNT_W'(2)))
		else $error("sorting a set of fewer than two records");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending record left behind at end of set");

	a_final_flush: assert property (@(posedge clk) disable iff (!arst_n)
		out_load_final |=> (out_valid_q && out_final_q && !pend_v_q))
		else $error("final transfer not staged");
`endif

endmodule
